[rtl/core/pdv_pkg.sv]
`default_nettype none

package pdv_pkg;

    // number formats
    localparam int unsigned VEL_W   = 32;
    localparam int unsigned MASS_W  = 48;
    localparam int unsigned DT_W    = 48;
    localparam int unsigned ACC_W   = 256;
    localparam int unsigned QUO_W   = 41;

    // cd*pi/2 in unsigned q2.30
    localparam logic [31:0] DRAG_K          = 32'd2023955653;
    // 0.005 m in q0.32
    localparam logic [31:0] DEFAULT_RADIUS  = 32'd21474836;
    localparam logic [47:0] TIME_STEP_RESET = 48'd2814749767;
    localparam logic [40:0] DELTA_CAP       = 41'd1 << 40;
    localparam int unsigned RESCALE_BITS    = 133;

    // register byte addresses
    localparam logic [3:0] ADDR_TIME_STEP = 4'd0;

    // particle data carried down the pipeline
    typedef struct packed {
        logic             apply;
        logic [2:0][31:0] vel;
        logic [2:0]       neg;
        logic [2:0][31:0] absrel;
        logic [47:0]      mass;
        logic [31:0]      radius;
        logic [31:0]      rho;
    } t_item;

    // even and odd limb partial products of a wide multiply
    typedef struct packed {
        logic [ACC_W-1:0] e;
        logic [ACC_W-1:0] o;
    } t_pp;

    // wide value times 32 bit scalar, one 32x32 product per limb
    function automatic t_pp f_pp(input logic [ACC_W-1:0] a, input logic [31:0] b);
        logic [ACC_W+63:0] e;
        logic [ACC_W+63:0] o;
        logic [63:0]       p;
        t_pp               r;
        e = '0;
        o = '0;
        for (int j = 0; j < ACC_W / 32; j++) begin
            p = 64'(a[32*j +: 32]) * 64'(b);
            if ((j & 1) == 0) begin
                e[32*j +: 64] = p;
            end else begin
                o[32*j +: 64] = p;
            end
        end
        r.e = e[ACC_W-1:0];
        r.o = o[ACC_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/core/particle_drag_velocity_update_core.sv]
`default_nettype none
// Quadratic drag velocity update for a stream of particles.
// Input channel: i_valid / o_stall with the particle and its cell gas data as
// separate ports; a transaction is taken at a clock edge with i_valid high and
// o_stall low. Output channel: o_valid / i_stall with the new velocity and the
// drag_applied flag.
// Throughput is one particle per cycle unless the output stalls. A particle
// passes through 83 register stages up to o_valid: 38 cover the relative velocity,
// the 32-step square root and the scalar products, then 45 cover the per-axis
// product, the 41-step restoring divide by mass and the saturating add.
// All stages move on one enable; while o_valid is high and i_stall is high the
// whole pipeline holds and o_stall is raised, so nothing is lost or repeated.
// The time step is to be written over the APB port (64 bit data, byte address 0)
// only while the block is idle; the block itself does not enforce this. Reads return it.
// Synchronous active low reset empties the pipeline and sets the time step to
// about 1e-5 s. No clearing pass is needed.
module particle_drag_velocity_update_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // apb configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic      [63:0] prdata,
    output logic             pready,
    // particle input
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic        i_is_detached,
    input  wire logic        i_is_failed,
    input  wire logic [31:0] i_vel_x,
    input  wire logic [31:0] i_vel_y,
    input  wire logic [31:0] i_vel_z,
    input  wire logic [47:0] i_mass,
    input  wire logic [31:0] i_radius,
    input  wire logic [31:0] i_gas_density,
    input  wire logic [31:0] i_gas_vel_x,
    input  wire logic [31:0] i_gas_vel_y,
    input  wire logic [31:0] i_gas_vel_z,
    input  wire logic        i_gas_valid,
    // result output
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [31:0] o_new_vel_x,
    output logic      [31:0] o_new_vel_y,
    output logic      [31:0] o_new_vel_z,
    output logic             o_drag_applied
);

    localparam int unsigned NM = 38;
    localparam int unsigned NL = 44;
    localparam int unsigned SQ_FIRST = 4;
    localparam int unsigned DIV_FIRST = 3;

    logic        en;
    logic        acc_in;
    logic [47:0] r_time_step;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time_step <= pdv_pkg::TIME_STEP_RESET;
        end else if (psel && penable && pwrite && paddr == pdv_pkg::ADDR_TIME_STEP) begin
            r_time_step <= pwdata[47:0];
        end
    end
    assign prdata = (paddr == pdv_pkg::ADDR_TIME_STEP) ? {16'd0, r_time_step} : 64'd0;

    // global pipeline enable
    assign en      = !o_valid || !i_stall;
    assign o_stall = o_valid && i_stall;
    assign acc_in  = i_valid && !o_stall;

    // relative velocity and input fixups
    logic [2:0][31:0] w_vel;
    logic [2:0][31:0] w_gas;
    pdv_pkg::t_item   n_item;

    assign w_vel = {i_vel_z, i_vel_y, i_vel_x};
    assign w_gas = {i_gas_vel_z, i_gas_vel_y, i_gas_vel_x};

    for (genvar c = 0; c < 3; c++) begin : g_rel
        logic [32:0] w_rel;
        logic [32:0] w_nrel;
        assign w_rel  = {w_gas[c][31], w_gas[c]} - {w_vel[c][31], w_vel[c]};
        assign w_nrel = -w_rel;
        assign n_item.neg[c]    = w_rel[32];
        assign n_item.absrel[c] = w_rel[32] ? w_nrel[31:0] : w_rel[31:0];
        assign n_item.vel[c]    = w_vel[c];
    end
    assign n_item.apply  = (i_is_detached || i_is_failed) && i_gas_valid;
    assign n_item.mass   = (i_mass == 48'd0) ? 48'd1 : i_mass;
    assign n_item.radius = (i_radius == 32'd0) ? pdv_pkg::DEFAULT_RADIUS : i_radius;
    assign n_item.rho    = i_gas_density;

    // main pipeline: scalar products and square root
    logic [NM-1:0]             r_mv;
    pdv_pkg::t_item            r_mit  [NM];
    logic [pdv_pkg::ACC_W-1:0] r_acc  [NM];
    logic [pdv_pkg::ACC_W-1:0] r_aux  [NM];
    logic [63:0]               r_rem  [NM];
    logic [63:0]               r_root [NM];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mv <= '0;
        end else if (en) begin
            r_mv <= {r_mv[NM-2:0], acc_in};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_mit[0]  <= n_item;
            r_acc[0]  <= pdv_pkg::ACC_W'(i_valid ? r_time_step : r_time_step);
            r_aux[0]  <= '0;
            r_rem[0]  <= '0;
            r_root[0] <= '0;
        end
    end

    for (genvar s = 1; s < NM; s++) begin : g_main
        // accumulator: multiply steps are a partial product stage then an add stage
        if (s == 1 || s == 3 || s == 5 || s == 7 || s == 36) begin : g_pp
            logic [31:0] w_b;
            pdv_pkg::t_pp w_pp;
            if (s == 1) begin : g_k
                assign w_b = pdv_pkg::DRAG_K;
            end else if (s == 3) begin : g_rho
                assign w_b = r_mit[s-1].rho;
            end else if (s == 36) begin : g_mag
                assign w_b = r_root[s-1][31:0];
            end else begin : g_r
                assign w_b = r_mit[s-1].radius;
            end
            assign w_pp = pdv_pkg::f_pp(r_acc[s-1], w_b);
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_acc[s] <= w_pp.e;
                    r_aux[s] <= w_pp.o;
                end
            end
        end else if (s == 2 || s == 4 || s == 6 || s == 8 || s == 37) begin : g_add
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_acc[s] <= r_acc[s-1] + r_aux[s-1];
                    r_aux[s] <= '0;
                end
            end
        end else begin : g_pass
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_acc[s] <= r_acc[s-1];
                    r_aux[s] <= '0;
                end
            end
        end

        // sum of squared half magnitudes, then one root bit per stage
        if (s == 1) begin : g_sq0
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[s]  <= 64'(r_mit[s-1].absrel[0][31:1]) *
                                 64'(r_mit[s-1].absrel[0][31:1]);
                    r_root[s] <= 64'(r_mit[s-1].absrel[1][31:1]) *
                                 64'(r_mit[s-1].absrel[1][31:1]);
                end
            end
        end else if (s == 2) begin : g_sq1
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[s]  <= r_rem[s-1] + r_root[s-1];
                    r_root[s] <= 64'(r_mit[s-1].absrel[2][31:1]) *
                                 64'(r_mit[s-1].absrel[2][31:1]);
                end
            end
        end else if (s == 3) begin : g_sq2
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[s]  <= r_rem[s-1] + r_root[s-1];
                    r_root[s] <= '0;
                end
            end
        end else if (s >= SQ_FIRST && s < SQ_FIRST + 32) begin : g_sqrt
            localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * (s - SQ_FIRST));
            logic [63:0] w_try;
            assign w_try = r_root[s-1] + SQ_BIT;
            always_ff @(posedge i_clk) begin
                if (en) begin
                    if (r_rem[s-1] >= w_try) begin
                        r_rem[s]  <= r_rem[s-1] - w_try;
                        r_root[s] <= (r_root[s-1] >> 1) + SQ_BIT;
                    end else begin
                        r_rem[s]  <= r_rem[s-1];
                        r_root[s] <= r_root[s-1] >> 1;
                    end
                end
            end
        end else begin : g_sqpass
            always_ff @(posedge i_clk) begin
                if (en) begin
                    r_rem[s]  <= r_rem[s-1];
                    r_root[s] <= r_root[s-1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mit[s] <= r_mit[s-1];
            end
        end
    end

    // lane pipeline: per axis product, divide by mass
    logic [NL-1:0]             r_lv;
    pdv_pkg::t_item            r_lit [NL];
    logic [pdv_pkg::ACC_W-1:0] r_lp  [NL][3];
    logic [pdv_pkg::ACC_W-1:0] r_lo  [NL][3];
    logic [40:0]               r_dn  [NL][3];
    logic [47:0]               r_dr  [NL][3];
    logic [40:0]               r_dq  [NL][3];
    logic [2:0]                r_dov [NL];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= '0;
        end else if (en) begin
            r_lv <= {r_lv[NL-2:0], r_mv[NM-1]};
        end
    end

    for (genvar s = 0; s < NL; s++) begin : g_lane
        pdv_pkg::t_item w_it;
        if (s == 0) begin : g_src
            assign w_it = r_mit[NM-1];
        end else begin : g_prev
            assign w_it = r_lit[s-1];
        end
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lit[s] <= w_it;
            end
        end

        for (genvar c = 0; c < 3; c++) begin : g_ax
            if (s == 0) begin : g_pp
                pdv_pkg::t_pp w_pp;
                assign w_pp = pdv_pkg::f_pp(r_acc[NM-1], w_it.absrel[c]);
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_lp[s][c] <= w_pp.e;
                        r_lo[s][c] <= w_pp.o;
                    end
                end
            end else if (s == 1) begin : g_add
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_lp[s][c] <= r_lp[s-1][c] + r_lo[s-1][c];
                    end
                end
            end else if (s == 2) begin : g_setup
                // rescaled numerator; a high part at or above the mass caps the quotient
                logic [106:0] w_num;
                assign w_num = r_lp[s-1][c][pdv_pkg::RESCALE_BITS +: 107];
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dn[s][c]  <= w_num[40:0];
                        r_dr[s][c]  <= w_num[88:41];
                        r_dq[s][c]  <= '0;
                        r_dov[s][c] <= (w_num[106:41] >= 66'(w_it.mass));
                    end
                end
            end else begin : g_div
                localparam int unsigned BIT = 40 - (s - DIV_FIRST);
                logic [48:0] w_try;
                assign w_try = {r_dr[s-1][c], r_dn[s-1][c][BIT]};
                always_ff @(posedge i_clk) begin
                    if (en) begin
                        r_dn[s][c]  <= r_dn[s-1][c];
                        r_dov[s][c] <= r_dov[s-1][c];
                        if (w_try >= {1'b0, w_it.mass}) begin
                            r_dr[s][c] <= 48'(w_try - {1'b0, w_it.mass});
                            r_dq[s][c] <= {r_dq[s-1][c][39:0], 1'b1};
                        end else begin
                            r_dr[s][c] <= w_try[47:0];
                            r_dq[s][c] <= {r_dq[s-1][c][39:0], 1'b0};
                        end
                    end
                end
            end
        end
    end

    // clamp, signed add and saturation into the output register; velocity unchanged when drag does not apply
    logic             r_ov;
    logic [2:0][31:0] r_nv;
    logic             r_drag;
    logic [2:0][31:0] n_nv;

    for (genvar c = 0; c < 3; c++) begin : g_out
        logic [40:0] w_d;
        logic [41:0] w_v;
        logic [41:0] w_sum;
        pdv_pkg::t_item w_it;
        assign w_it  = r_lit[NL-1];
        assign w_d   = (r_dov[NL-1][c] || r_dq[NL-1][c] > pdv_pkg::DELTA_CAP) ?
                       pdv_pkg::DELTA_CAP : r_dq[NL-1][c];
        assign w_v   = {{10{w_it.vel[c][31]}}, w_it.vel[c]};
        assign w_sum = w_it.neg[c] ? (w_v - {1'b0, w_d}) : (w_v + {1'b0, w_d});
        always_comb begin
            if (!w_it.apply) begin
                n_nv[c] = w_it.vel[c];
            end else if (!w_sum[41] && w_sum[40:31] != 10'd0) begin
                n_nv[c] = 32'h7fff_ffff;
            end else if (w_sum[41] && w_sum[40:31] != 10'h3ff) begin
                n_nv[c] = 32'h8000_0000;
            end else begin
                n_nv[c] = w_sum[31:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_lv[NL-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_nv   <= n_nv;
            r_drag <= r_lit[NL-1].apply;
        end
    end

    assign o_valid        = r_ov;
    assign o_new_vel_x    = r_nv[0];
    assign o_new_vel_y    = r_nv[1];
    assign o_new_vel_z    = r_nv[2];
    assign o_drag_applied = r_drag;

endmodule

`default_nettype wire

[rtl/core/pdv_check.sv]
`default_nettype none

module pdv_check (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic [31:0] o_new_vel_x,
    input wire logic [31:0] o_new_vel_y,
    input wire logic [31:0] o_new_vel_z,
    input wire logic        o_drag_applied
);

    // input side is held back only by a waiting result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // a result that is not taken is not dropped
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> o_valid)
        else $error("stalled result dropped");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown after reset");

    // drag flag and velocity hold while stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(o_drag_applied) && $stable(o_new_vel_x)
            && $stable(o_new_vel_y) && $stable(o_new_vel_z)))
        else $error("stalled result changed");

endmodule

bind particle_drag_velocity_update_core pdv_check u_pdv_check (.*);

`default_nettype wire
